[hw/rtl/i2cmp_pkg.sv]
// Shared types and constants for the motor PWM register target.
package i2cmp_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int MAX_RESULTS  = 4;
   localparam int CNT_W        = $clog2(MAX_RESULTS);

   localparam logic [7:0]  LEFT_CODE_RST  = 8'h10;
   localparam logic [7:0]  RIGHT_CODE_RST = 8'h11;
   localparam logic [15:0] WRAP_LIMIT_RST = 16'hFFFF;

   typedef enum logic [2:0] {
      ACT_BYTE   = 3'd0,
      ACT_READ   = 3'd1,
      ACT_FINISH = 3'd2,
      ACT_SET    = 3'd3,
      ACT_APPLY  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      REG_LEFT_CODE  = 2'd0,
      REG_RIGHT_CODE = 2'd1,
      REG_WRAP_LIMIT = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_COMMAND = 3'b001,
      PH_HIGH    = 3'b010,
      PH_LOW     = 3'b100
   } write_phase_type;

   localparam logic RK_TX   = 1'b0;
   localparam logic RK_DUTY = 1'b1;

   typedef struct packed {
      logic byte_en;
      logic read_en;
      logic finish_en;
      logic set_en;
      logic emit;
      logic emit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic any_dirty;
      logic more_dirty;
   } dp_status_type;

endpackage

[hw/rtl/i2cmp_if.sv]
// Channel interfaces: request, response and register write.
interface i2cmp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  rx_byte;
   logic [15:0] left_ticks;
   logic [15:0] right_ticks;
   modport source (output valid, action, rx_byte, left_ticks, right_ticks, input ready);
   modport sink (input valid, action, rx_byte, left_ticks, right_ticks, output ready);
endinterface

interface i2cmp_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  tx_byte;
   logic [1:0]  channel;
   logic [15:0] duty_level;
   logic        last;
   modport source (output valid, result_kind, tx_byte, channel, duty_level, last, input ready);
   modport sink (input valid, result_kind, tx_byte, channel, duty_level, last, output ready);
endinterface

interface i2cmp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

[hw/rtl/i2cmp_ctrl.sv]
// Controller: transaction decode and apply sequencing.
module i2cmp_ctrl
   import i2cmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [2:0]    req_action,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } ctrl_state_type;

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_BYTE:   cmd.byte_en   = 1'b1;
                  ACT_READ:   cmd.read_en   = 1'b1;
                  ACT_FINISH: cmd.finish_en = 1'b1;
                  ACT_SET:    cmd.set_en    = 1'b1;
                  ACT_APPLY: begin
                     state_in = ST_APPLY;
                     cnt_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_APPLY: begin
            if (!status.any_dirty) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               // stop after four updates even if more channels are dirty
               cmd.emit_last = (cnt_ff == CNT_W'(MAX_RESULTS - 1)) || !status.more_dirty;
               cnt_in        = cnt_ff + 1'b1;
               if (cmd.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[hw/rtl/i2cmp_dp.sv]
// Datapath: register file, duty targets, dirty marks and the response register.
module i2cmp_dp
   import i2cmp_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [7:0]    rx_byte,
   input  logic [15:0]   left_ticks,
   input  logic [15:0]   right_ticks,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic          rsp_result_kind,
   output logic [7:0]    rsp_tx_byte,
   output logic [1:0]    rsp_channel,
   output logic [15:0]   rsp_duty_level,
   output logic          rsp_last
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [7:0]      left_code_ff, left_code_in;
   logic [7:0]      right_code_ff, right_code_in;
   logic [15:0]     wrap_ff, wrap_in;
   write_phase_type phase_ff, phase_in;
   logic [CH_W-1:0] latch_ch_ff, latch_ch_in;
   logic [7:0]      high_ff, high_in;
   logic            sel_right_ff, sel_right_in;
   logic            selected_ff, selected_in;
   logic            byte_idx_ff, byte_idx_in;
   logic [15:0]     duty_ff [CHANNELS];
   logic [15:0]     duty_in [CHANNELS];
   logic [CHANNELS-1:0] dirty_ff, dirty_in;
   logic [15:0]     left_val_ff, left_val_in;
   logic [15:0]     right_val_ff, right_val_in;

   logic            valid_ff, valid_in;
   logic            kind_ff, kind_in;
   logic [7:0]      tx_ff, tx_in;
   logic [1:0]      chan_ff, chan_in;
   logic [15:0]     level_ff, level_in;
   logic            last_ff, last_in;

   logic [CH_W-1:0]     first_idx;
   logic [CHANNELS-1:0] first_onehot;
   logic [15:0]         enc_val;
   logic [15:0]         target;

   // lowest dirty channel
   always_comb begin
      first_idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (dirty_ff[i]) begin
            first_idx = CH_W'(i);
         end
      end
   end

   assign first_onehot      = CHANNELS'(1) << first_idx;
   assign status.out_free   = !valid_ff || rsp_ready;
   assign status.any_dirty  = |dirty_ff;
   assign status.more_dirty = |(dirty_ff & ~first_onehot);

   assign enc_val = !selected_ff ? 16'h0000 : (sel_right_ff ? right_val_ff : left_val_ff);
   assign target  = duty_ff[first_idx];

   always_comb begin
      left_code_in  = left_code_ff;
      right_code_in = right_code_ff;
      wrap_in       = wrap_ff;
      phase_in      = phase_ff;
      latch_ch_in   = latch_ch_ff;
      high_in       = high_ff;
      sel_right_in  = sel_right_ff;
      selected_in   = selected_ff;
      byte_idx_in   = byte_idx_ff;
      duty_in       = duty_ff;
      dirty_in      = dirty_ff;
      left_val_in   = left_val_ff;
      right_val_in  = right_val_ff;
      valid_in      = valid_ff && !rsp_ready;
      kind_in       = kind_ff;
      tx_in         = tx_ff;
      chan_in       = chan_ff;
      level_in      = level_ff;
      last_in       = last_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_LEFT_CODE:  left_code_in  = csr_wdata[7:0];
            REG_RIGHT_CODE: right_code_in = csr_wdata[7:0];
            REG_WRAP_LIMIT: wrap_in       = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.byte_en) begin
         unique case (phase_ff)
            PH_HIGH: begin
               high_in  = rx_byte;
               phase_in = PH_LOW;
            end
            PH_LOW: begin
               duty_in[latch_ch_ff]  = {high_ff, rx_byte};
               dirty_in[latch_ch_ff] = 1'b1;
               phase_in              = PH_COMMAND;
            end
            default: begin
               phase_in = PH_COMMAND;
               // encoder codes take priority over channel numbers; left wins a tie
               if (rx_byte == left_code_ff || rx_byte == right_code_ff) begin
                  sel_right_in = (rx_byte != left_code_ff);
                  selected_in  = 1'b1;
               end else if (rx_byte < 8'(CHANNELS)) begin
                  latch_ch_in = CH_W'(rx_byte);
                  phase_in    = PH_HIGH;
               end
            end
         endcase
      end

      if (cmd.finish_en) begin
         phase_in    = PH_COMMAND;
         byte_idx_in = 1'b0;
      end

      if (cmd.set_en) begin
         left_val_in  = left_ticks;
         right_val_in = right_ticks;
      end

      if (cmd.read_en) begin
         valid_in = 1'b1;
         kind_in  = RK_TX;
         chan_in  = '0;
         level_in = '0;
         last_in  = 1'b1;
         if (!byte_idx_ff) begin
            tx_in       = enc_val[15:8];
            byte_idx_in = 1'b1;
         end else begin
            tx_in       = enc_val[7:0];
            byte_idx_in = 1'b0;
            selected_in = 1'b0;
         end
      end

      if (cmd.emit) begin
         valid_in            = 1'b1;
         kind_in             = RK_DUTY;
         tx_in               = '0;
         chan_in             = 2'(first_idx);
         level_in            = (target > wrap_ff) ? wrap_ff : target;
         last_in             = cmd.emit_last;
         dirty_in[first_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_code_ff  <= LEFT_CODE_RST;
         right_code_ff <= RIGHT_CODE_RST;
         wrap_ff       <= WRAP_LIMIT_RST;
         phase_ff      <= PH_COMMAND;
         latch_ch_ff   <= '0;
         high_ff       <= '0;
         sel_right_ff  <= 1'b0;
         selected_ff   <= 1'b0;
         byte_idx_ff   <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            duty_ff[i] <= '0;
         end
         dirty_ff      <= '0;
         left_val_ff   <= '0;
         right_val_ff  <= '0;
         valid_ff      <= 1'b0;
      end else begin
         left_code_ff  <= left_code_in;
         right_code_ff <= right_code_in;
         wrap_ff       <= wrap_in;
         phase_ff      <= phase_in;
         latch_ch_ff   <= latch_ch_in;
         high_ff       <= high_in;
         sel_right_ff  <= sel_right_in;
         selected_ff   <= selected_in;
         byte_idx_ff   <= byte_idx_in;
         duty_ff       <= duty_in;
         dirty_ff      <= dirty_in;
         left_val_ff   <= left_val_in;
         right_val_ff  <= right_val_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      tx_ff    <= tx_in;
      chan_ff  <= chan_in;
      level_ff <= level_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_tx_byte     = tx_ff;
   assign rsp_channel     = chan_ff;
   assign rsp_duty_level  = level_ff;
   assign rsp_last        = last_ff;

endmodule

[hw/rtl/i2c_motor_pwm_register_target.sv]
// Byte-level register target: takes bus bytes, read requests, finish, encoder
// updates and apply events one transaction at a time, and takes a transaction
// only while the response register is free (or being emptied). A read request
// yields one transmit byte. An apply emits one duty update per dirty channel
// (at most four, lowest dirty channels first), each update waiting on the
// response register; with nothing dirty it produces no response. Register
// writes are always ready.
module i2c_motor_pwm_register_target
   import i2cmp_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input logic        clock,
   input logic        reset,
   i2cmp_req_if.sink   req_if,
   i2cmp_rsp_if.source rsp_if,
   i2cmp_csr_if.sink   csr_if
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_if.ready = 1'b1;

   i2cmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .status     (status),
      .cmd        (cmd)
   );

   i2cmp_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rx_byte         (req_if.rx_byte),
      .left_ticks      (req_if.left_ticks),
      .right_ticks     (req_if.right_ticks),
      .csr_valid       (csr_if.valid),
      .csr_index       (csr_if.index),
      .csr_wdata       (csr_if.wdata),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_result_kind (rsp_if.result_kind),
      .rsp_tx_byte     (rsp_if.tx_byte),
      .rsp_channel     (rsp_if.channel),
      .rsp_duty_level  (rsp_if.duty_level),
      .rsp_last        (rsp_if.last)
   );

endmodule

[hw/rtl/i2cmp_checker.sv]
// Port-level checks for the register target, bound to the top level.
module i2cmp_props
   import i2cmp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [7:0]  rsp_tx_byte,
   input logic [1:0]  rsp_channel,
   input logic [15:0] rsp_duty_level,
   input logic        rsp_last
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_kind) &&
         $stable(rsp_tx_byte) && $stable(rsp_channel) && $stable(rsp_duty_level) &&
         $stable(rsp_last)))
      else $error("response changed while stalled");

   // a read transaction yields its byte in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_READ) |=> rsp_valid)
      else $error("read transaction without response");

   // transactions that produce nothing leave the response side empty
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action != ACT_READ && req_action != ACT_APPLY)
         |=> !rsp_valid)
      else $error("unexpected response");

   // a transmit byte is always a lone, final response with empty duty fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == RK_TX) |->
         (rsp_last && rsp_channel == 2'd0 && rsp_duty_level == 16'd0))
      else $error("malformed transmit response");

endmodule

bind i2c_motor_pwm_register_target i2cmp_props u_i2cmp_props (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_action      (req_if.action),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_result_kind (rsp_if.result_kind),
   .rsp_tx_byte     (rsp_if.tx_byte),
   .rsp_channel     (rsp_if.channel),
   .rsp_duty_level  (rsp_if.duty_level),
   .rsp_last        (rsp_if.last)
);
